/* hw/rtl/lerb_pkg.sv */
// shared constants, types and tables of the elevation ring binner
package lerb_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int CNT_W      = PT_AW + 1;
  localparam int MAX_RINGS  = 64;
  localparam int RING_AW    = $clog2(MAX_RINGS);
  localparam int RING_CW    = RING_AW + 1;
  localparam int STEPS      = 20;
  localparam int STEP_W     = 5;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_FRAME = 2'd2;

  localparam logic [1:0] CFG_LOWER = 2'd0;
  localparam logic [1:0] CFG_SCALE = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  typedef struct packed {
    logic ld_in;
    logic rd_start;
    logic frame_clr;
    logic sq_mul;
    logic sq_sum;
    logic sqrt_init;
    logic sqrt_step;
    logic cord_init;
    logic cord_step;
    logic ring_mul;
    logic ring_chk;
    logic ring_rd_ld;
    logic ld_wr;
    logic scan_eval;
    logic walk_eval;
    logic emit_pt;
    logic emit_empty;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic step_done;
    logic ring_ok;
    logic rd_empty;
    logic cache_same;
    logic scan_end;
    logic scan_hit;
    logic pos_zero;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [PT_AW-1:0] head;
    logic [PT_AW-1:0] tail;
  } ring_ent_t;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
    logic [7:0]         inten;
  } point_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/lerb_ctrl.sv */
// sequencing state machine of the elevation ring binner
module lerb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_command,
  output logic           in_stall,
  input  lerb_pkg::sts_t sts,
  output lerb_pkg::cmd_t cmd
);

  typedef enum logic [17:0] {
    S_IDLE      = 18'h00001,
    S_SQ_MUL    = 18'h00002,
    S_SQ_SUM    = 18'h00004,
    S_SQ_CHK    = 18'h00008,
    S_SQRT      = 18'h00010,
    S_CORD_INIT = 18'h00020,
    S_CORD      = 18'h00040,
    S_RING_MUL  = 18'h00080,
    S_RING_CHK  = 18'h00100,
    S_LD_RD     = 18'h00200,
    S_LD_WR     = 18'h00400,
    S_SCAN_A    = 18'h00800,
    S_SCAN_B    = 18'h01000,
    S_WALK_A    = 18'h02000,
    S_WALK_B    = 18'h04000,
    S_FETCH     = 18'h08000,
    S_EMIT      = 18'h10000,
    S_EMIT_E    = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            lerb_pkg::CMD_LOAD: begin
              cmd.ld_in = 1'b1;
              state_nxt = S_SQ_MUL;
            end
            lerb_pkg::CMD_READ: begin
              cmd.rd_start = 1'b1;
              if (sts.rd_empty) state_nxt = S_EMIT_E;
              else if (sts.cache_same) state_nxt = S_WALK_A;
              else state_nxt = S_SCAN_A;
            end
            lerb_pkg::CMD_FRAME: cmd.frame_clr = 1'b1;
            default: ;
          endcase
        end
      end
      S_SQ_MUL: begin
        cmd.sq_mul = 1'b1;
        state_nxt  = S_SQ_SUM;
      end
      S_SQ_SUM: begin
        cmd.sq_sum = 1'b1;
        state_nxt  = S_SQ_CHK;
      end
      S_SQ_CHK: begin
        if (sts.drop) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.sqrt_init = 1'b1;
          state_nxt     = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.step_done) state_nxt = S_CORD_INIT;
      end
      S_CORD_INIT: begin
        cmd.cord_init = 1'b1;
        state_nxt     = S_CORD;
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        if (sts.step_done) state_nxt = S_RING_MUL;
      end
      S_RING_MUL: begin
        cmd.ring_mul = 1'b1;
        state_nxt    = S_RING_CHK;
      end
      S_RING_CHK: begin
        cmd.ring_chk = 1'b1;
        state_nxt    = sts.ring_ok ? S_LD_RD : S_IDLE;
      end
      S_LD_RD: begin
        cmd.ring_rd_ld = 1'b1;
        state_nxt      = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.ld_wr = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN_A: begin
        state_nxt = sts.scan_end ? S_EMIT_E : S_SCAN_B;
      end
      S_SCAN_B: begin
        cmd.scan_eval = 1'b1;
        state_nxt     = sts.scan_hit ? S_WALK_A : S_SCAN_A;
      end
      S_WALK_A: begin
        state_nxt = sts.pos_zero ? S_FETCH : S_WALK_B;
      end
      S_WALK_B: begin
        cmd.walk_eval = 1'b1;
        state_nxt     = S_WALK_A;
      end
      S_FETCH: state_nxt = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_pt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_EMIT_E: begin
        if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/lerb_dp.sv */
// datapath: elevation arithmetic, ring lists, point store and output register
module lerb_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic signed [19:0]  in_x,
  input  logic signed [19:0]  in_y,
  input  logic signed [19:0]  in_z,
  input  logic [7:0]          in_intensity,
  input  logic                in_finite,
  input  logic                out_stall,
  output logic                out_valid,
  output logic                out_has_point,
  output logic signed [19:0]  out_x,
  output logic signed [19:0]  out_y,
  output logic signed [19:0]  out_z,
  output logic [7:0]          out_intensity,
  output logic [5:0]          out_ring_index,
  output logic [11:0]         out_index,
  output logic [11:0]         out_range_first,
  output logic                out_ring_last,
  input  lerb_pkg::cmd_t      cmd,
  output lerb_pkg::sts_t      sts
);

  localparam int PA = lerb_pkg::PT_AW;
  localparam int CW = lerb_pkg::CNT_W;
  localparam int RA = lerb_pkg::RING_AW;
  localparam int RC = lerb_pkg::RING_CW;
  localparam logic signed [43:0] HALF    = 44'sd8388608;
  localparam logic signed [43:0] NEG_ONE = -44'sd16777216;

  // configuration
  logic signed [15:0] lower_r;
  logic [23:0]        scale_r;
  logic [6:0]         count_r;

  // captured point
  logic signed [19:0] px_r, py_r, pz_r;
  logic [7:0]         pi_r;
  logic               pf_r;

  logic [39:0] xx_r, yy_r, zz_r;
  logic [39:0] rr_sum;
  logic [40:0] all3;
  logic signed [39:0] xs, ys, zs;
  logic        drop_r;

  // square root and cordic
  logic [39:0]            rad_r;
  logic [21:0]            rem_r;
  logic [19:0]            root_r;
  logic [lerb_pkg::STEP_W-1:0] step_r;
  logic [23:0]            r4, trial;
  logic                   ge;
  logic signed [31:0]     cx_r, cy_r, dx, dy;
  logic signed [23:0]     acc_r, atan_s, acc_rnd;
  logic signed [15:0]     elev;
  logic signed [17:0]     diff;
  logic signed [24:0]     sc25;
  logic signed [42:0]     prod;
  logic signed [43:0]     t_r;
  logic [19:0]            quo;
  logic [RC-1:0]          limit;
  logic                   t_ok;
  logic [RA-1:0]          ring_calc, ring_r;

  // frame state
  logic [CW-1:0]          total_r, cursor_r;
  logic [lerb_pkg::MAX_RINGS-1:0] ring_vld_r;
  lerb_pkg::ring_ent_t    ring_mem [lerb_pkg::MAX_RINGS];
  lerb_pkg::ring_ent_t    ring_q, ring_wd;
  logic                   ring_vq;
  logic [RA-1:0]          ring_ra;
  logic [PA-1:0]          nxt_mem [lerb_pkg::MAX_POINTS];
  logic [PA-1:0]          nxt_q;
  lerb_pkg::point_t       st_mem [lerb_pkg::MAX_POINTS];
  lerb_pkg::point_t       st_q;
  logic [PA-1:0]          wr_k;

  // read walk
  logic [RC-1:0] scan_r;
  logic [CW-1:0] first_r, pos_r, sel_cnt_r, scan_cnt;
  logic [CW:0]   scan_lim;
  logic [PA-1:0] k_r;
  logic [RA-1:0] sel_ring_r;
  logic          last_calc;

  // position of the last point read, lets the next read skip or shorten the scan
  logic          c_vld_r, c_last_r;
  logic [RA-1:0] c_ring_r;
  logic [CW-1:0] c_first_r, c_cnt_r;
  logic [PA-1:0] c_k_r;

  logic out_vld_r;

  assign xs = px_r * px_r;
  assign ys = py_r * py_r;
  assign zs = pz_r * pz_r;
  assign rr_sum = xx_r + yy_r;
  assign all3   = {1'b0, rr_sum} + {1'b0, zz_r};

  assign r4    = {rem_r, rad_r[39:38]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = (r4 >= trial);

  assign dx     = cy_r >>> step_r;
  assign dy     = cx_r >>> step_r;
  assign atan_s = $signed({2'b00, lerb_pkg::atan_lut(step_r)});

  assign acc_rnd = acc_r + 24'sd128;
  assign elev    = acc_rnd[23:8];
  assign diff    = $signed({{2{elev[15]}}, elev}) - $signed({{2{lower_r[15]}}, lower_r});
  assign sc25    = $signed({1'b0, scale_r});
  assign prod    = diff * sc25;

  // truncation toward zero leaves small negative values in ring zero
  assign quo   = t_r[43:24];
  assign limit = (count_r > RC'(lerb_pkg::MAX_RINGS)) ? RC'(lerb_pkg::MAX_RINGS) : count_r;
  always_comb begin
    if (t_r[43]) begin
      t_ok      = (t_r > NEG_ONE) && (limit != '0);
      ring_calc = '0;
    end else begin
      t_ok      = (quo < {13'd0, limit});
      ring_calc = quo[RA-1:0];
    end
  end

  assign ring_ra  = cmd.ring_rd_ld ? ring_r : scan_r[RA-1:0];
  assign wr_k     = total_r[PA-1:0];
  assign scan_cnt = ring_vq ? ring_q.cnt : '0;
  assign scan_lim = {1'b0, first_r} + {1'b0, scan_cnt};
  assign last_calc = (cursor_r == first_r + sel_cnt_r - CW'(1));

  always_comb begin
    if (ring_vq) begin
      ring_wd.cnt  = ring_q.cnt + CW'(1);
      ring_wd.head = ring_q.head;
    end else begin
      ring_wd.cnt  = CW'(1);
      ring_wd.head = wr_k;
    end
    ring_wd.tail = wr_k;
  end

  assign sts.drop       = drop_r;
  assign sts.step_done  = (step_r == lerb_pkg::STEP_W'(lerb_pkg::STEPS - 1));
  assign sts.ring_ok    = t_ok && (total_r < CW'(lerb_pkg::MAX_POINTS));
  assign sts.rd_empty   = (cursor_r >= total_r);
  assign sts.cache_same = c_vld_r && !c_last_r;
  assign sts.scan_end   = (scan_r == RC'(lerb_pkg::MAX_RINGS));
  assign sts.scan_hit   = ({1'b0, cursor_r} < scan_lim);
  assign sts.pos_zero   = (pos_r == '0);
  assign sts.out_free   = !out_vld_r || !out_stall;

  assign out_valid = out_vld_r;

  // memories
  always_ff @(posedge clk) begin
    ring_q  <= ring_mem[ring_ra];
    ring_vq <= ring_vld_r[ring_ra];
    nxt_q   <= nxt_mem[k_r];
    st_q    <= st_mem[k_r];
    if (cmd.ld_wr) begin
      ring_mem[ring_r] <= ring_wd;
      st_mem[wr_k]     <= '{x: px_r, y: py_r, z: pz_r, inten: pi_r};
      if (ring_vq) nxt_mem[ring_q.tail] <= wr_k;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      px_r <= in_x;
      py_r <= in_y;
      pz_r <= in_z;
      pi_r <= in_intensity;
      pf_r <= in_finite;
    end
    if (cmd.sq_mul) begin
      xx_r <= $unsigned(xs);
      yy_r <= $unsigned(ys);
      zz_r <= $unsigned(zs);
    end
    if (cmd.sq_sum) begin
      drop_r <= !pf_r || (all3 < 41'd100);
      rad_r  <= rr_sum;
    end
    if (cmd.sqrt_init) begin
      rem_r  <= '0;
      root_r <= '0;
      step_r <= '0;
    end
    if (cmd.sqrt_step) begin
      rem_r  <= ge ? 22'(r4 - trial) : r4[21:0];
      root_r <= {root_r[18:0], ge};
      rad_r  <= {rad_r[37:0], 2'b00};
      step_r <= step_r + 1'b1;
    end
    if (cmd.cord_init) begin
      cx_r   <= $signed({4'd0, root_r, 8'd0});
      cy_r   <= $signed({{4{pz_r[19]}}, pz_r, 8'd0});
      acc_r  <= '0;
      step_r <= '0;
    end
    if (cmd.cord_step) begin
      if (!cy_r[31]) begin
        cx_r  <= cx_r + dx;
        cy_r  <= cy_r - dy;
        acc_r <= acc_r + atan_s;
      end else begin
        cx_r  <= cx_r - dx;
        cy_r  <= cy_r + dy;
        acc_r <= acc_r - atan_s;
      end
      step_r <= step_r + 1'b1;
    end
    if (cmd.ring_mul) t_r <= {prod[42], prod} + HALF;
    if (cmd.ring_chk) ring_r <= ring_calc;

    if (cmd.rd_start) begin
      if (c_vld_r && !c_last_r) begin
        k_r        <= c_k_r;
        pos_r      <= CW'(1);
        sel_ring_r <= c_ring_r;
        sel_cnt_r  <= c_cnt_r;
        first_r    <= c_first_r;
      end else if (c_vld_r) begin
        scan_r  <= {1'b0, c_ring_r} + RC'(1);
        first_r <= c_first_r + c_cnt_r;
      end else begin
        scan_r  <= '0;
        first_r <= '0;
      end
    end
    if (cmd.scan_eval) begin
      if ({1'b0, cursor_r} < scan_lim) begin
        sel_ring_r <= scan_r[RA-1:0];
        sel_cnt_r  <= scan_cnt;
        pos_r      <= cursor_r - first_r;
        k_r        <= ring_q.head;
      end else begin
        first_r <= scan_lim[CW-1:0];
        scan_r  <= scan_r + RC'(1);
      end
    end
    if (cmd.walk_eval) begin
      k_r   <= nxt_q;
      pos_r <= pos_r - CW'(1);
    end
    if (cmd.emit_pt) begin
      out_has_point   <= 1'b1;
      out_x           <= st_q.x;
      out_y           <= st_q.y;
      out_z           <= st_q.z;
      out_intensity   <= st_q.inten;
      out_ring_index  <= sel_ring_r;
      out_index       <= cursor_r[11:0];
      out_range_first <= first_r[11:0];
      out_ring_last   <= last_calc;
      c_last_r        <= last_calc;
      c_ring_r        <= sel_ring_r;
      c_first_r       <= first_r;
      c_cnt_r         <= sel_cnt_r;
      c_k_r           <= k_r;
    end
    if (cmd.emit_empty) begin
      out_has_point   <= 1'b0;
      out_x           <= '0;
      out_y           <= '0;
      out_z           <= '0;
      out_intensity   <= '0;
      out_ring_index  <= '0;
      out_index       <= '0;
      out_range_first <= '0;
      out_ring_last   <= 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r    <= -16'sd3840;
      scale_r    <= 24'd262144;
      count_r    <= 7'd16;
      total_r    <= '0;
      cursor_r   <= '0;
      ring_vld_r <= '0;
      c_vld_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lerb_pkg::CFG_LOWER: lower_r <= cfg_data[15:0];
          lerb_pkg::CFG_SCALE: scale_r <= cfg_data;
          lerb_pkg::CFG_COUNT: count_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (cmd.frame_clr) begin
        total_r    <= '0;
        cursor_r   <= '0;
        ring_vld_r <= '0;
        c_vld_r    <= 1'b0;
      end
      if (cmd.ld_wr) begin
        ring_vld_r[ring_r] <= 1'b1;
        total_r            <= total_r + CW'(1);
        c_vld_r            <= 1'b0;
      end
      if (cmd.emit_pt) begin
        cursor_r <= cursor_r + CW'(1);
        c_vld_r  <= 1'b1;
      end
      if (cmd.emit_pt || cmd.emit_empty) out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
    end
  end

endmodule

/* hw/rtl/lidar_elevation_ring_binner_unit.sv */
// load request: squaring, 20-step square root, 20-step cordic, ring multiply, list append
// read request: after a read that did not end its ring it walks on, else it scans rings first;
// frame request: clears the frame; one request in flight at a time
// results sit in an output register, so loads go on while a result waits
// synchronous active-low reset clears the ring list valid bits, counters and config defaults
module lidar_elevation_ring_binner_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [19:0] in_x,
  input  logic signed [19:0] in_y,
  input  logic signed [19:0] in_z,
  input  logic [7:0]         in_intensity,
  input  logic               in_finite,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_has_point,
  output logic signed [19:0] out_x,
  output logic signed [19:0] out_y,
  output logic signed [19:0] out_z,
  output logic [7:0]         out_intensity,
  output logic [5:0]         out_ring_index,
  output logic [11:0]        out_index,
  output logic [11:0]        out_range_first,
  output logic               out_ring_last
);

  lerb_pkg::cmd_t cmd;
  lerb_pkg::sts_t sts;

  lerb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  lerb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_x            (in_x),
    .in_y            (in_y),
    .in_z            (in_z),
    .in_intensity    (in_intensity),
    .in_finite       (in_finite),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_has_point   (out_has_point),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z),
    .out_intensity   (out_intensity),
    .out_ring_index  (out_ring_index),
    .out_index       (out_index),
    .out_range_first (out_range_first),
    .out_ring_last   (out_ring_last),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
